// ===== rtl/fapc_pkg.sv =====
// Shared types and constants for the fire alarm pump controller.
package fapc_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COOLDOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_TIME   = 2'd1;

  localparam logic [CFG_W-1:0] CONFIRM_TIME_RESET = 16'd2000;
  localparam logic [CFG_W-1:0] CLEAR_TIME_RESET   = 16'd5000;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              flame_seen;
    logic              manual_override;
  } fapc_poll_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              alarm_on;
    logic              pump_on;
    logic              fire_notify;
  } fapc_result_t;

  typedef struct packed {
    logic [CFG_W-1:0] confirm_time_ms;
    logic [CFG_W-1:0] clear_time_ms;
  } fapc_cfg_t;

endpackage

// ===== rtl/fapc_if.sv =====
// Channel interfaces: poll input, result output and configuration writes.
interface fapc_poll_if;
  import fapc_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_ms;
  logic              flame_seen;
  logic              manual_override;
  modport source (output valid, time_ms, flame_seen, manual_override, input ready);
  modport sink (input valid, time_ms, flame_seen, manual_override, output ready);
endinterface

interface fapc_result_if;
  import fapc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              alarm_on;
  logic              pump_on;
  logic              fire_notify;
  modport source (output valid, mode, alarm_on, pump_on, fire_notify, input ready);
  modport sink (input valid, mode, alarm_on, pump_on, fire_notify, output ready);
endinterface

interface fapc_cfg_if;
  import fapc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/fapc_cfg_regs.sv =====
// Configuration registers: confirm and clear times.
module fapc_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  fapc_cfg_if.sink            cfg,
  output fapc_pkg::fapc_cfg_t cfg_regs
);
  import fapc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.confirm_time_ms <= CONFIRM_TIME_RESET;
      cfg_regs.clear_time_ms   <= CLEAR_TIME_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_CONFIRM_TIME: cfg_regs.confirm_time_ms <= cfg.data;
        REG_CLEAR_TIME:   cfg_regs.clear_time_ms   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/fapc_core.sv =====
// Mode state and per-poll update logic.
module fapc_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  fapc_pkg::fapc_poll_t   item,
  input  fapc_pkg::fapc_cfg_t    cfg_regs,
  output fapc_pkg::fapc_result_t res
);
  import fapc_pkg::*;

  logic [MODE_W-1:0] mode_reg, mode_reg_next;
  logic [TIME_W-1:0] first_seen_time, first_seen_time_next;
  logic              first_seen_valid, first_seen_valid_next;
  logic [TIME_W-1:0] last_seen_time, last_seen_time_next;
  logic              notified_flag, notified_flag_next;
  logic              alarm_reg, alarm_reg_next;
  logic              pump_reg, pump_reg_next;
  logic              notify;
  logic [TIME_W-1:0] since_last;
  logic [TIME_W-1:0] since_first;
  logic [TIME_W-1:0] clear_time;
  logic [TIME_W-1:0] calm_time;
  logic [TIME_W-1:0] confirm_time;

  assign clear_time   = TIME_W'(cfg_regs.clear_time_ms);
  assign calm_time    = TIME_W'({cfg_regs.clear_time_ms, 1'b0});
  assign confirm_time = TIME_W'(cfg_regs.confirm_time_ms);

  always_comb begin
    last_seen_time_next   = last_seen_time;
    first_seen_time_next  = first_seen_time;
    first_seen_valid_next = first_seen_valid;
    if (item.flame_seen) begin
      last_seen_time_next = item.time_ms;
      if (!first_seen_valid) begin
        first_seen_time_next  = item.time_ms;
        first_seen_valid_next = 1'b1;
      end
    end else begin
      first_seen_valid_next = 1'b0;
      first_seen_time_next  = '0;
    end

    since_last  = item.time_ms - last_seen_time_next;
    since_first = item.time_ms - first_seen_time_next;

    mode_reg_next      = mode_reg;
    notified_flag_next = notified_flag;
    alarm_reg_next     = alarm_reg;
    pump_reg_next      = pump_reg;
    notify             = 1'b0;

    case (mode_reg)
      MODE_FIRE: begin
        if (!item.flame_seen && since_last >= clear_time) begin
          mode_reg_next  = MODE_COOLDOWN;
          alarm_reg_next = 1'b0;
          pump_reg_next  = 1'b0;
        end
      end
      MODE_COOLDOWN: begin
        if (item.flame_seen) begin
          mode_reg_next  = MODE_FIRE;
          alarm_reg_next = 1'b1;
          pump_reg_next  = 1'b1;
        end else if (since_last >= calm_time) begin
          mode_reg_next      = MODE_NORMAL;
          notified_flag_next = 1'b0;
        end
      end
      default: begin
        if (item.flame_seen && since_first >= confirm_time) begin
          mode_reg_next  = MODE_FIRE;
          alarm_reg_next = 1'b1;
          pump_reg_next  = 1'b1;
          if (!notified_flag) begin
            notify             = 1'b1;
            notified_flag_next = 1'b1;
          end
        end
      end
    endcase

    if (item.manual_override) begin
      pump_reg_next = 1'b1;
    end

    res.mode        = mode_reg_next;
    res.alarm_on    = alarm_reg_next;
    res.pump_on     = pump_reg_next;
    res.fire_notify = notify;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg         <= MODE_NORMAL;
      first_seen_time  <= '0;
      first_seen_valid <= 1'b0;
      last_seen_time   <= '0;
      notified_flag    <= 1'b0;
      alarm_reg        <= 1'b0;
      pump_reg         <= 1'b0;
    end else if (step) begin
      mode_reg         <= mode_reg_next;
      first_seen_time  <= first_seen_time_next;
      first_seen_valid <= first_seen_valid_next;
      last_seen_time   <= last_seen_time_next;
      notified_flag    <= notified_flag_next;
      alarm_reg        <= alarm_reg_next;
      pump_reg         <= pump_reg_next;
    end
  end

endmodule

// ===== rtl/fire_alarm_pump_controller_unit.sv =====
// Top level of the fire alarm pump controller.
//
// Channels: poll (sink) takes one sensor poll per item: time_ms, flame_seen,
// manual_override. result (source) returns one item per poll: mode,
// alarm_on, pump_on, fire_notify. cfg (sink) writes confirm_time_ms
// (index 0) and clear_time_ms (index 1); it is always ready.
// A poll is captured in an input register; when the result register is free or
// being taken, the mode logic evaluates it, updates the controller state and
// loads the result register. Throughput is one item per cycle while result is
// not stalled. While result is stalled the result register holds and the input
// register still takes one more poll; poll.ready drops only when both are full.
// Reset clears both registers, puts the mode to normal with alarm and pump
// off, and restores the confirm and clear times to 2000 and 5000 ms.
module fire_alarm_pump_controller_unit (
  input logic           clk,
  input logic           rst,
  fapc_cfg_if.sink      cfg,
  fapc_poll_if.sink     poll,
  fapc_result_if.source result
);
  import fapc_pkg::*;

  logic         stage_valid;
  fapc_poll_t   stage_item;
  logic         advance;
  fapc_cfg_t    cfg_regs;
  fapc_result_t res_next;
  fapc_result_t res_q;
  logic         res_valid;

  assign advance    = stage_valid && (!res_valid || result.ready);
  assign poll.ready = !stage_valid || advance;

  fapc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_regs (cfg_regs)
  );

  fapc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (stage_item),
    .cfg_regs (cfg_regs),
    .res      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (poll.ready) begin
      stage_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      stage_item.time_ms         <= poll.time_ms;
      stage_item.flame_seen      <= poll.flame_seen;
      stage_item.manual_override <= poll.manual_override;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || result.ready) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid       = res_valid;
  assign result.mode        = res_q.mode;
  assign result.alarm_on    = res_q.alarm_on;
  assign result.pump_on     = res_q.pump_on;
  assign result.fire_notify = res_q.fire_notify;

  a_notify_in_fire: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.fire_notify |-> result.mode == MODE_FIRE && result.alarm_on)
    else $error("notify outside fire mode");

  a_alarm_tracks_fire: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.alarm_on == (result.mode == MODE_FIRE))
    else $error("alarm level does not match mode");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_item))
    else $error("stalled poll lost");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("evaluated poll produced no result");

endmodule

// ===== dv/fapc_result_checker.sv =====
// Checker for the fire alarm pump controller: watches the channels, predicts results, compares.
`timescale 1ns / 1ps
module fapc_result_checker (
  input  logic          clk,
  input  logic          rst,
  fapc_cfg_if           cfg,
  fapc_poll_if          poll,
  fapc_result_if        result,
  output int            mismatches,
  output int            pending
);
  import fapc_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [TIME_W-1:0] onset_ms;
  logic              onset_valid;
  logic [TIME_W-1:0] last_flame_ms;
  logic              notified;
  logic              alarm_q;
  logic              pump_q;
  logic [CFG_W-1:0]  confirm_ms;
  logic [CFG_W-1:0]  clear_ms;

  fapc_result_t results_due[$];
  int           error_count;

  function automatic fapc_result_t advance_controller(input logic [TIME_W-1:0] now,
                                                      input logic flame,
                                                      input logic override_req);
    fapc_result_t      res;
    logic [TIME_W-1:0] calm_ms;
    logic [TIME_W-1:0] hold_ms;
    logic [TIME_W-1:0] confirm_wide;
    logic              notify;
    calm_ms      = {15'd0, clear_ms, 1'b0};
    hold_ms      = {16'd0, clear_ms};
    confirm_wide = {16'd0, confirm_ms};
    notify       = 1'b0;
    if (flame) begin
      last_flame_ms = now;
      if (!onset_valid) begin
        onset_ms    = now;
        onset_valid = 1'b1;
      end
    end else begin
      onset_valid = 1'b0;
      onset_ms    = '0;
    end
    case (mode_q)
      MODE_FIRE: begin
        if (!flame && (now - last_flame_ms) >= hold_ms) begin
          mode_q  = MODE_COOLDOWN;
          alarm_q = 1'b0;
          pump_q  = 1'b0;
        end
      end
      MODE_COOLDOWN: begin
        if (flame) begin
          mode_q  = MODE_FIRE;
          alarm_q = 1'b1;
          pump_q  = 1'b1;
        end else if ((now - last_flame_ms) >= calm_ms) begin
          mode_q   = MODE_NORMAL;
          notified = 1'b0;
        end
      end
      default: begin
        if (flame && (now - onset_ms) >= confirm_wide) begin
          mode_q  = MODE_FIRE;
          alarm_q = 1'b1;
          pump_q  = 1'b1;
          if (!notified) begin
            notify   = 1'b1;
            notified = 1'b1;
          end
        end
      end
    endcase
    if (override_req) pump_q = 1'b1;
    res.mode        = mode_q;
    res.alarm_on    = alarm_q;
    res.pump_on     = pump_q;
    res.fire_notify = notify;
    return res;
  endfunction

  always @(posedge clk) begin
    fapc_result_t want;
    if (rst) begin
      mode_q        = MODE_NORMAL;
      onset_ms      = '0;
      onset_valid   = 1'b0;
      last_flame_ms = '0;
      notified      = 1'b0;
      alarm_q       = 1'b0;
      pump_q        = 1'b0;
      confirm_ms    = CONFIRM_TIME_RESET;
      clear_ms      = CLEAR_TIME_RESET;
      results_due.delete();
      error_count   = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_CONFIRM_TIME: confirm_ms = cfg.data;
          REG_CLEAR_TIME:   clear_ms   = cfg.data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (results_due.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: mode %0d alarm %0d pump %0d notify %0d",
                     result.mode, result.alarm_on, result.pump_on, result.fire_notify);
        end else begin
          want = results_due.pop_front();
          if (result.mode !== want.mode || result.alarm_on !== want.alarm_on ||
              result.pump_on !== want.pump_on || result.fire_notify !== want.fire_notify) begin
            error_count++;
            if (error_count <= 10)
              $display("result mismatch: expected mode %0d alarm %0d pump %0d notify %0d, %s",
                       want.mode, want.alarm_on, want.pump_on, want.fire_notify,
                       $sformatf("got mode %0d alarm %0d pump %0d notify %0d",
                                 result.mode, result.alarm_on, result.pump_on,
                                 result.fire_notify));
          end
        end
      end
      if (poll.valid && poll.ready)
        results_due.push_back(advance_controller(poll.time_ms, poll.flame_seen,
                                                 poll.manual_override));
    end
    mismatches <= error_count;
    pending    <= results_due.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the fire alarm pump controller: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
  import fapc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 215;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   sender_idle_pct;
  int   sink_stall_pct;
  int   stall_cycles;
  int   cur_confirm;
  int   cur_clear;
  logic [TIME_W-1:0] clock_ms;
  logic              flame_run;

  fapc_cfg_if    cfg_ch();
  fapc_poll_if   poll_ch();
  fapc_result_if result_ch();

  fire_alarm_pump_controller_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .poll   (poll_ch),
    .result (result_ch)
  );

  fapc_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .poll       (poll_ch),
    .result     (result_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_poll(input logic [TIME_W-1:0] t, input logic flame, input logic ovr);
    while ($urandom_range(99) < sender_idle_pct) begin
      poll_ch.valid <= 1'b0;
      @(negedge clk);
    end
    poll_ch.valid           <= 1'b1;
    poll_ch.time_ms         <= t;
    poll_ch.flame_seen      <= flame;
    poll_ch.manual_override <= ovr;
    do @(posedge clk); while (!poll_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    poll_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_times(input int confirm, input int clear, input bit spare);
    write_reg(REG_CONFIRM_TIME, confirm[CFG_W-1:0]);
    write_reg(REG_CLEAR_TIME, clear[CFG_W-1:0]);
    if (spare) begin
      write_reg(REG_SPARE_LO, 16'hFFFF);
      write_reg(REG_SPARE_HI, 16'h0000);
    end
    cfg_ch.valid <= 1'b0;
    cur_confirm = confirm;
    cur_clear   = clear;
  endtask

  task automatic run_episodes(input int count);
    int                span;
    int                pick;
    logic [TIME_W-1:0] step;
    span = (cur_confirm > 2 * cur_clear) ? cur_confirm : 2 * cur_clear;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(299) == 0) drain_results();
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_poll($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        if (pick < 20)
          step = '0;
        else if (pick < 28)
          step = span + $urandom_range(span);
        else
          step = $urandom_range(span / 4 + 2);
        clock_ms = clock_ms + step;
        if ($urandom_range(7) == 0) flame_run = ~flame_run;
        send_poll(clock_ms, flame_run, $urandom_range(99) < 8);
      end
    end
  endtask

  initial begin
    int confirm_set[6];
    int clear_set[6];
    rst                     = 1'b1;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = REG_CONFIRM_TIME;
    cfg_ch.data             = '0;
    poll_ch.valid           = 1'b0;
    poll_ch.time_ms         = '0;
    poll_ch.flame_seen      = 1'b0;
    poll_ch.manual_override = 1'b0;
    sender_idle_pct         = 28;
    sink_stall_pct          = 84;
    cur_confirm             = int'(CONFIRM_TIME_RESET);
    cur_clear               = int'(CLEAR_TIME_RESET);
    flame_run               = 1'b0;
    clock_ms                = '0;
    confirm_set = '{0, 65535, 2000, 0, 65535, $urandom_range(400, 1)};
    clear_set   = '{0, 65535, 5000, 65535, 0, $urandom_range(400, 1)};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // flame onset at time zero, confirm, override, cooldown and return
    send_poll(32'd0, 1'b0, 1'b0);
    send_poll(32'd0, 1'b1, 1'b0);
    send_poll(32'd1000, 1'b1, 1'b0);
    send_poll(32'd2000, 1'b1, 1'b0);
    send_poll(32'd2100, 1'b0, 1'b1);
    send_poll(32'd7100, 1'b0, 1'b0);
    send_poll(32'd7150, 1'b0, 1'b1);
    send_poll(32'd7200, 1'b1, 1'b0);
    send_poll(32'd12200, 1'b0, 1'b0);
    send_poll(32'd17199, 1'b0, 1'b0);
    send_poll(32'd17200, 1'b0, 1'b0);
    // confirm across the timestamp wrap
    send_poll(32'hFFFF_FC18, 1'b1, 1'b0);
    send_poll(32'h0000_03E7, 1'b1, 1'b0);
    send_poll(32'h0000_03E8, 1'b1, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_poll(32'h5555_5555, 1'b1, 1'b1);
    send_poll(32'hAAAA_AAAA, 1'b1, 1'b0);
    // zero confirm and zero clear times
    drain_results();
    load_times(0, 0, 1'b1);
    send_poll(32'd100, 1'b0, 1'b0);
    send_poll(32'd100, 1'b0, 1'b0);
    send_poll(32'd101, 1'b1, 1'b0);
    send_poll(32'd101, 1'b0, 1'b0);
    send_poll(32'd101, 1'b0, 1'b0);
    send_poll(32'd102, 1'b1, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph / 2)
        0: begin
          sender_idle_pct = 28;
          sink_stall_pct  = 84;
        end
        1: begin
          sender_idle_pct = 84;
          sink_stall_pct  = 28;
        end
        default: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
      endcase
      load_times(confirm_set[ph], clear_set[ph], ph == 1);
      clock_ms = (ph % 2 == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(200000);
      run_episodes(PHASE_ITEMS);
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fapc_pkg.sv
rtl/fapc_if.sv
rtl/fapc_cfg_regs.sv
rtl/fapc_core.sv
rtl/fire_alarm_pump_controller_unit.sv
dv/fapc_result_checker.sv
dv/tb.sv
